// ----- src/i2cms_pkg.sv -----
// Shared types and constants for the I2C master transfer sequencer.
package i2cms_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int QDEPTH    = 3;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_EVENT = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_RESET = 3'd1,
        ACT_START = 3'd2,
        ACT_SEND  = 3'd3,
        ACT_STOP  = 3'd4,
        ACT_ACK   = 3'd5,
        ACT_NACK  = 3'd6
    } action_t;

    // Bus status codes with the low three bits dropped.
    typedef enum logic [4:0] {
        ST_START         = 5'h01,
        ST_REP_START     = 5'h02,
        ST_TX_ADDR_ACK   = 5'h03,
        ST_TX_ADDR_NACK  = 5'h04,
        ST_TX_DATA_ACK   = 5'h05,
        ST_TX_DATA_NACK  = 5'h06,
        ST_ARB_LOST      = 5'h07,
        ST_RX_ADDR_ACK   = 5'h08,
        ST_RX_ADDR_NACK  = 5'h09,
        ST_RX_DATA_ACK   = 5'h0A,
        ST_RX_DATA_NACK  = 5'h0B
    } status_t;

    typedef enum logic [1:0] {
        TX_ZERO = 2'd0,
        TX_ADDR = 2'd1,
        TX_BUF  = 2'd2
    } tx_src_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] slave_addr;
        logic       read_not_write;
        logic [5:0] length;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [4:0] buf_index;
        logic [7:0] buf_value;
    } in_item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic [7:0] buf_read;
        logic       busy_res;
        logic [5:0] remaining;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } buf_req_t;

    typedef struct packed {
        action_t          action;
        tx_src_t          tx_src;
        logic             rd_en;
        logic [7:0]       addr_byte;
        logic             busy;
        logic [CNT_W-1:0] remaining;
    } ctrl_res_t;

endpackage

// ----- src/i2cms_ctrl.sv -----
// Transfer state and the per-item bus action decision, with its result register.
module i2cms_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  i2cms_pkg::in_item_t item,
    output i2cms_pkg::buf_req_t buf_req,
    output logic                res_valid,
    output i2cms_pkg::ctrl_res_t res
);

    localparam logic [i2cms_pkg::CNT_W-1:0] DEPTH_CNT =
        i2cms_pkg::CNT_W'(i2cms_pkg::BUF_DEPTH);
    localparam logic [i2cms_pkg::CNT_W-1:0] ONE_CNT = i2cms_pkg::CNT_W'(1);

    logic [7:0]                  addr_byte_reg, addr_byte_next;
    logic [i2cms_pkg::CNT_W-1:0] left_reg, left_next;
    logic [i2cms_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic                        active_reg, active_next;
    logic                        res_valid_reg;
    i2cms_pkg::ctrl_res_t        res_reg, res_next;

    i2cms_pkg::status_t          status;
    logic                        ptr_ok;
    logic [i2cms_pkg::CNT_W-1:0] ptr_adv;
    logic [i2cms_pkg::CNT_W-1:0] left_dec;
    logic [i2cms_pkg::CNT_W-1:0] len_sat;
    logic                        wr_en;
    logic [i2cms_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                  wr_data;

    always_comb
    begin
        status   = i2cms_pkg::status_t'(item.status_code[7:3]);
        ptr_ok   = ptr_reg < DEPTH_CNT;
        ptr_adv  = ptr_ok ? ptr_reg + ONE_CNT : ptr_reg;
        left_dec = (left_reg != '0) ? left_reg - ONE_CNT : left_reg;
        len_sat  = (int'(item.length) > i2cms_pkg::BUF_DEPTH) ? DEPTH_CNT
                                                               : i2cms_pkg::CNT_W'(item.length);

        addr_byte_next = addr_byte_reg;
        left_next      = left_reg;
        ptr_next       = ptr_reg;
        active_next    = active_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[i2cms_pkg::ADDR_W-1:0];
        wr_data        = item.rx_byte;
        res_next       = '0;
        res_next.action = i2cms_pkg::ACT_NONE;
        res_next.tx_src = i2cms_pkg::TX_ZERO;

        unique case (item.cmd)
            i2cms_pkg::CMD_START:
            begin
                addr_byte_next  = {item.slave_addr, item.read_not_write};
                left_next       = len_sat;
                ptr_next        = '0;
                active_next     = 1'b1;
                res_next.action = i2cms_pkg::ACT_START;
            end
            i2cms_pkg::CMD_EVENT:
            begin
                if (active_reg)
                begin
                    unique case (status)
                        i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START:
                        begin
                            res_next.action = i2cms_pkg::ACT_SEND;
                            res_next.tx_src = i2cms_pkg::TX_ADDR;
                        end
                        i2cms_pkg::ST_RX_DATA_ACK:
                        begin
                            wr_en     = ptr_ok;
                            ptr_next  = ptr_adv;
                            left_next = left_dec;
                            res_next.action = (left_dec > ONE_CNT) ? i2cms_pkg::ACT_ACK
                                                                   : i2cms_pkg::ACT_NACK;
                        end
                        i2cms_pkg::ST_RX_ADDR_ACK:
                        begin
                            res_next.action = (left_reg > ONE_CNT) ? i2cms_pkg::ACT_ACK
                                                                   : i2cms_pkg::ACT_NACK;
                        end
                        i2cms_pkg::ST_RX_DATA_NACK:
                        begin
                            // The final byte is stored but the pointer stays put.
                            wr_en           = ptr_ok;
                            left_next       = left_dec;
                            res_next.action = i2cms_pkg::ACT_STOP;
                        end
                        i2cms_pkg::ST_TX_ADDR_ACK, i2cms_pkg::ST_TX_DATA_ACK:
                        begin
                            if (left_reg != '0)
                            begin
                                left_next       = left_dec;
                                ptr_next        = ptr_adv;
                                res_next.action = i2cms_pkg::ACT_SEND;
                                res_next.tx_src = ptr_ok ? i2cms_pkg::TX_BUF
                                                         : i2cms_pkg::TX_ZERO;
                            end
                            else
                            begin
                                res_next.action = i2cms_pkg::ACT_STOP;
                            end
                        end
                        i2cms_pkg::ST_TX_ADDR_NACK, i2cms_pkg::ST_TX_DATA_NACK,
                        i2cms_pkg::ST_RX_ADDR_NACK:
                        begin
                            res_next.action = i2cms_pkg::ACT_STOP;
                        end
                        i2cms_pkg::ST_ARB_LOST:
                        begin
                            res_next.action = i2cms_pkg::ACT_START;
                        end
                        default:
                        begin
                            res_next.action = i2cms_pkg::ACT_RESET;
                        end
                    endcase
                    if (res_next.action == i2cms_pkg::ACT_STOP ||
                        res_next.action == i2cms_pkg::ACT_RESET)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            i2cms_pkg::CMD_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = i2cms_pkg::ADDR_W'(item.buf_index);
                wr_data = item.buf_value;
            end
            i2cms_pkg::CMD_READ:
            begin
                res_next.rd_en = 1'b1;
            end
            default:
            begin
                res_next.action = i2cms_pkg::ACT_NONE;
            end
        endcase

        res_next.addr_byte = addr_byte_reg;
        res_next.busy      = active_next;
        res_next.remaining = left_next;

        buf_req.wr_en   = accept && wr_en;
        buf_req.wr_addr = wr_addr;
        buf_req.wr_data = wr_data;
        buf_req.rd_en   = accept;
        buf_req.rd_addr = (item.cmd == i2cms_pkg::CMD_READ)
                          ? i2cms_pkg::ADDR_W'(item.buf_index)
                          : ptr_reg[i2cms_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_byte_reg <= '0;
            left_reg      <= '0;
            ptr_reg       <= '0;
            active_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= accept;
            if (accept)
            begin
                addr_byte_reg <= addr_byte_next;
                left_reg      <= left_next;
                ptr_reg       <= ptr_next;
                active_reg    <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- src/i2cms_buf.sv -----
// Transfer data buffer: one write port and one registered read port.
module i2cms_buf
(
    input  logic                clk,
    input  i2cms_pkg::buf_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0] mem [i2cms_pkg::BUF_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/i2cms_outq.sv -----
// Small result queue that decouples the decision stage from a stalling receiver.
module i2cms_outq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  i2cms_pkg::out_item_t         push_item,
    output logic                         valid,
    input  logic                         stall,
    output i2cms_pkg::out_item_t         item,
    output logic [i2cms_pkg::QCNT_W-1:0] level
);

    localparam logic [i2cms_pkg::QPTR_W-1:0] LAST_PTR = i2cms_pkg::QPTR_W'(i2cms_pkg::QDEPTH - 1);
    localparam logic [i2cms_pkg::QPTR_W-1:0] ONE_PTR  = i2cms_pkg::QPTR_W'(1);
    localparam logic [i2cms_pkg::QCNT_W-1:0] ONE_CNT  = i2cms_pkg::QCNT_W'(1);

    i2cms_pkg::out_item_t              q_reg [i2cms_pkg::QDEPTH];
    logic [i2cms_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [i2cms_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [i2cms_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                              pop;

    always_comb
    begin
        pop         = (count_reg != '0) && !stall;
        wr_ptr_next = push ? ((wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + ONE_PTR)
                           : wr_ptr_reg;
        rd_ptr_next = pop ? ((rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + ONE_PTR)
                          : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + ONE_CNT;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ONE_CNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign valid = count_reg != '0;
    assign item  = q_reg[rd_ptr_reg];
    assign level = count_reg;

endmodule

// ----- src/i2c_master_transfer_sequencer.sv -----
// Top level of the I2C master transfer sequencer.
//
// Input channel (item_valid / item_stall / item): one command per item: start
// a transfer, report a bus status event, load a buffer byte or read one back.
// Output channel (result_valid / result_stall / result): exactly one result
// per accepted item, in order: the bus action to take, the byte to send, the
// buffer byte read, the busy flag and the bytes still to move.
// The result is registered in the decision stage and then passes through the
// result queue before result_valid rises; one item is accepted every cycle
// while item_stall is low. The decision is a single
// registered pass, and the buffer byte comes from the registered read port
// of the 32-entry data buffer, read at the accepting edge.
// A three-entry result queue sits behind the decision stage. item_stall rises
// only when the queue and the stage together hold three results, so a
// receiver that stalls for a while stops intake after up to three items.
// Reset clears the transfer state, the queue and all valid flags; buffer
// contents are undefined until written.
module i2c_master_transfer_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  i2cms_pkg::in_item_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output i2cms_pkg::out_item_t  result
);

    logic                          accept;
    i2cms_pkg::buf_req_t           buf_req;
    logic                          res_valid;
    i2cms_pkg::ctrl_res_t          res;
    logic [7:0]                    rdata;
    i2cms_pkg::out_item_t          push_item;
    logic [i2cms_pkg::QCNT_W-1:0]  level;

    assign item_stall = (int'(level) + int'(res_valid)) >= i2cms_pkg::QDEPTH;
    assign accept     = item_valid && !item_stall;

    i2cms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .buf_req   (buf_req),
        .res_valid (res_valid),
        .res       (res)
    );

    i2cms_buf u_buf
    (
        .clk   (clk),
        .req   (buf_req),
        .rdata (rdata)
    );

    always_comb
    begin
        push_item.action = res.action;
        unique case (res.tx_src)
            i2cms_pkg::TX_ADDR: push_item.tx_byte = res.addr_byte;
            i2cms_pkg::TX_BUF:  push_item.tx_byte = rdata;
            default:            push_item.tx_byte = '0;
        endcase
        push_item.buf_read  = res.rd_en ? rdata : '0;
        push_item.busy_res  = res.busy;
        push_item.remaining = 6'(res.remaining);
    end

    i2cms_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (push_item),
        .valid     (result_valid),
        .stall     (result_stall),
        .item      (result),
        .level     (level)
    );

endmodule

// ----- src/i2cms_checker.sv -----
// Port-level checks for the I2C master transfer sequencer, bound to the top level.
module i2cms_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input i2cms_pkg::out_item_t result
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result item changed");

    // With nothing waiting at the output there is always room for an item.
    a_room_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("intake stalled with an empty result queue");

    a_stop_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == i2cms_pkg::ACT_STOP ||
                         result.action == i2cms_pkg::ACT_RESET) |-> !result.busy_res)
        else $error("stop or reset left the transfer busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action == i2cms_pkg::ACT_START |-> result.busy_res)
        else $error("start reported without a busy transfer");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the I2C master transfer sequencer.
module tb_top;
    import i2cms_pkg::*;

    localparam int LONG_HOLD      = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 10;
    localparam int MAX_REPORTS    = 10;

    // Status codes that the sequencer does not know.
    localparam logic [4:0] ST_UNKNOWN_LOW  = 5'h00;
    localparam logic [4:0] ST_UNKNOWN_MID  = 5'h0C;
    localparam logic [4:0] ST_UNKNOWN_HIGH = 5'h1F;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item_word    = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_word;

    // Shadow copy of the sequencer state.
    logic [7:0]  shadow_buf [BUF_DEPTH];
    logic [7:0]  shadow_addr  = '0;
    int unsigned shadow_left  = 0;
    int unsigned shadow_ptr   = 0;
    bit          shadow_busy  = 1'b0;

    out_item_t   pending_results [$];
    int          items_sent     = 0;
    int          error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_req_cnt   = 0;
    int          hold_ack_cnt   = 0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    i2c_master_transfer_sequencer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] shadow_get(input int unsigned pos);
        if (pos < BUF_DEPTH)
            return shadow_buf[pos];
        return 8'h00;
    endfunction

    function automatic void shadow_put(input int unsigned pos, input logic [7:0] v);
        if (pos < BUF_DEPTH)
            shadow_buf[pos] = v;
    endfunction

    // Computes the result of one item and advances the shadow state.
    function automatic out_item_t sequencer_next(input in_item_t it);
        out_item_t r;
        r = '0;
        r.action = ACT_NONE;
        case (it.cmd)
            CMD_START:
            begin
                shadow_addr = {it.slave_addr, it.read_not_write};
                shadow_left = (it.length > BUF_DEPTH) ? BUF_DEPTH : 32'(it.length);
                shadow_ptr  = 0;
                shadow_busy = 1'b1;
                r.action    = ACT_START;
            end
            CMD_EVENT:
            begin
                if (shadow_busy)
                begin
                    case (it.status_code[7:3])
                        ST_START, ST_REP_START:
                        begin
                            r.tx_byte = shadow_addr;
                            r.action  = ACT_SEND;
                        end
                        ST_RX_DATA_ACK:
                        begin
                            shadow_put(shadow_ptr, it.rx_byte);
                            if (shadow_ptr < BUF_DEPTH)
                                shadow_ptr++;
                            if (shadow_left > 0)
                                shadow_left--;
                            if (shadow_left > 1)
                                r.action = ACT_ACK;
                            else
                                r.action = ACT_NACK;
                        end
                        ST_RX_ADDR_ACK:
                        begin
                            if (shadow_left > 1)
                                r.action = ACT_ACK;
                            else
                                r.action = ACT_NACK;
                        end
                        ST_RX_DATA_NACK:
                        begin
                            // The final byte is stored but the pointer stays put.
                            shadow_put(shadow_ptr, it.rx_byte);
                            if (shadow_left > 0)
                                shadow_left--;
                            r.action = ACT_STOP;
                        end
                        ST_TX_ADDR_ACK, ST_TX_DATA_ACK:
                        begin
                            if (shadow_left > 0)
                            begin
                                shadow_left--;
                                r.tx_byte = shadow_get(shadow_ptr);
                                if (shadow_ptr < BUF_DEPTH)
                                    shadow_ptr++;
                                r.action = ACT_SEND;
                            end
                            else
                                r.action = ACT_STOP;
                        end
                        ST_TX_ADDR_NACK, ST_TX_DATA_NACK, ST_RX_ADDR_NACK:
                            r.action = ACT_STOP;
                        ST_ARB_LOST:
                            r.action = ACT_START;
                        default:
                            r.action = ACT_RESET;
                    endcase
                    if (r.action == ACT_STOP || r.action == ACT_RESET)
                        shadow_busy = 1'b0;
                end
            end
            CMD_LOAD:
                shadow_put(it.buf_index, it.buf_value);
            default:
                r.buf_read = shadow_get(it.buf_index);
        endcase
        r.busy_res  = shadow_busy;
        r.remaining = shadow_left[5:0];
        return r;
    endfunction

    // Fills every field at random so that unused fields toggle too.
    function automatic in_item_t rand_item(input cmd_t c);
        logic [63:0] bits;
        in_item_t    r;
        bits  = {$urandom(), $urandom()};
        r     = in_item_t'(bits[$bits(in_item_t)-1:0]);
        r.cmd = c;
        return r;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_word  <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(sequencer_next(it));
        items_sent++;
    endtask

    task automatic start_transfer(input logic [6:0] addr, input logic rnw,
                                  input logic [5:0] len);
        in_item_t it;
        it                = rand_item(CMD_START);
        it.slave_addr     = addr;
        it.read_not_write = rnw;
        it.length         = len;
        send_item(it);
    endtask

    task automatic send_event(input logic [4:0] code);
        in_item_t it;
        it                  = rand_item(CMD_EVENT);
        it.status_code[7:3] = code;
        send_item(it);
    endtask

    task automatic send_load(input logic [4:0] idx, input logic [7:0] val);
        in_item_t it;
        it           = rand_item(CMD_LOAD);
        it.buf_index = idx;
        it.buf_value = val;
        send_item(it);
    endtask

    task automatic send_read(input logic [4:0] idx);
        in_item_t it;
        it           = rand_item(CMD_READ);
        it.buf_index = idx;
        send_item(it);
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Every entry gets written first, so no read ever hits an unwritten entry.
    task automatic test_buffer_fill();
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (i == 0)
                send_load(5'(i), 8'h00);
            else if (i == 1)
                send_load(5'(i), 8'hFF);
            else
                send_load(5'(i), 8'($urandom_range(255)));
        end
        send_read(5'd0);
        send_read(5'd31);
    endtask

    task automatic test_write_transfer();
        start_transfer(7'h7F, 1'b0, 6'd3);
        send_event(ST_START);
        send_event(ST_TX_ADDR_ACK);
        send_event(ST_TX_DATA_ACK);
        send_event(ST_TX_DATA_ACK);
        // The count is at zero here, so this ends the transfer.
        send_event(ST_TX_DATA_ACK);
        // An event while idle is ignored.
        send_event(ST_TX_DATA_ACK);
    endtask

    task automatic test_read_transfer();
        start_transfer(7'h00, 1'b1, 6'd2);
        send_event(ST_REP_START);
        send_event(ST_RX_ADDR_ACK);
        send_event(ST_RX_DATA_ACK);
        send_event(ST_RX_DATA_NACK);
        send_read(5'd0);
        send_read(5'd1);
    endtask

    task automatic test_special_cases();
        // The length saturates, and a second start restarts the busy transfer.
        start_transfer(7'h55, 1'b0, 6'd63);
        start_transfer(7'h2A, 1'b1, 6'd0);
        send_event(ST_ARB_LOST);
        send_event(ST_RX_ADDR_ACK);
        send_event(ST_RX_DATA_ACK);
        send_event(ST_RX_ADDR_NACK);
        start_transfer(7'h11, 1'b1, 6'd1);
        send_event(ST_UNKNOWN_LOW);
        start_transfer(7'h22, 1'b0, 6'd32);
        send_event(ST_UNKNOWN_HIGH);
        start_transfer(7'h33, 1'b0, 6'd1);
        send_event(ST_TX_ADDR_NACK);
        start_transfer(7'h44, 1'b0, 6'd2);
        send_event(ST_TX_ADDR_ACK);
        send_event(ST_TX_DATA_NACK);
        start_transfer(7'h66, 1'b1, 6'd4);
        send_event(ST_UNKNOWN_MID);
    endtask

    // The receiver holds off at the start; a full-length read transfer then runs past the buffer end.
    task automatic test_backpressure();
        hold_req_cnt <= hold_req_cnt + 1;
        start_transfer(7'($urandom_range(127)), 1'b1, 6'd32);
        send_event(ST_START);
        send_event(ST_RX_ADDR_ACK);
        repeat (BUF_DEPTH + 2)
            send_event(ST_RX_DATA_ACK);
        send_event(ST_RX_DATA_NACK);
        send_read(5'd31);
        start_transfer(7'($urandom_range(127)), 1'b0, 6'd40);
        send_event(ST_START);
        send_event(ST_TX_ADDR_ACK);
        while (shadow_busy)
            send_event(ST_TX_DATA_ACK);
        wait_drain();
    endtask

    task automatic run_transfer();
        logic       rnw;
        int         p;
        logic [5:0] len;
        rnw = 1'($urandom_range(1));
        p   = $urandom_range(99);
        if (p < 70)
            len = 6'($urandom_range(6));
        else if (p < 90)
            len = 6'($urandom_range(32, 7));
        else
            len = 6'($urandom_range(63, 33));
        start_transfer(7'($urandom_range(127)), rnw, len);
        if ($urandom_range(1))
            send_event(ST_START);
        else
            send_event(ST_REP_START);
        if ($urandom_range(19) == 0)
            send_event(rnw ? ST_RX_ADDR_NACK : ST_TX_ADDR_NACK);
        else
        begin
            send_event(rnw ? ST_RX_ADDR_ACK : ST_TX_ADDR_ACK);
            while (shadow_busy)
            begin
                p = $urandom_range(99);
                if (p < 4)
                begin
                    send_event(ST_ARB_LOST);
                    send_event(ST_REP_START);
                end
                else if (p < 7)
                    send_event(rnw ? ST_RX_DATA_NACK : ST_TX_DATA_NACK);
                else if (!rnw)
                    send_event(ST_TX_DATA_ACK);
                else if (shadow_left > 1)
                    send_event(ST_RX_DATA_ACK);
                else
                    send_event(ST_RX_DATA_NACK);
            end
        end
    endtask

    task automatic test_random_traffic(input int count);
        int goal;
        int p;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            p = $urandom_range(99);
            if (p < 75)
                run_transfer();
            else if (p < 85)
                send_load(5'($urandom_range(31)), 8'($urandom_range(255)));
            else if (p < 92)
                send_read(5'($urandom_range(31)));
            else
                send_item(rand_item(cmd_t'($urandom_range(3))));
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_req_cnt != hold_ack_cnt)
        begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected result: action=%0d tx=%02h rd=%02h busy=%0b rem=%0d",
                             result_word.action, result_word.tx_byte, result_word.buf_read,
                             result_word.busy_res, result_word.remaining);
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (result_word.action !== exp.action || result_word.tx_byte !== exp.tx_byte
                    || result_word.buf_read !== exp.buf_read
                    || result_word.busy_res !== exp.busy_res
                    || result_word.remaining !== exp.remaining)
                begin
                    if (error_count < MAX_REPORTS)
                        $display({"mismatch: expected action=%0d tx=%02h rd=%02h busy=%0b ",
                                  "rem=%0d, got action=%0d tx=%02h rd=%02h busy=%0b rem=%0d"},
                                 exp.action, exp.tx_byte, exp.buf_read, exp.busy_res,
                                 exp.remaining, result_word.action, result_word.tx_byte,
                                 result_word.buf_read, result_word.busy_res,
                                 result_word.remaining);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL i2c_master_transfer_sequencer");
            $finish;
        end
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(10, 52);
        test_buffer_fill();
        test_write_transfer();
        test_read_transfer();
        test_special_cases();
        test_random_traffic(85);
        test_backpressure();

        set_idle(52, 10);
        test_random_traffic(85);

        set_idle(0, 0);
        test_random_traffic(90);

        wait_drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS i2c_master_transfer_sequencer");
        else
            $display("FAIL i2c_master_transfer_sequencer");
        $finish;
    end

endmodule
